@@ rtl/xywto_pkg.sv @@
// ----------------------------------------------------------------------------
// xywto_pkg
// Shared codes and constants for the XY wavetable oscillator.
// ----------------------------------------------------------------------------
package xywto_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_WAVE_MODE    = 2'd0;
   localparam logic [1:0] CSR_PHASE_STEP   = 2'd1;
   localparam logic [1:0] CSR_TABLE_LENGTH = 2'd2;

   // wave_mode codes; code 3 behaves as the point table
   localparam logic [1:0] WAVE_RECT  = 2'd0;
   localparam logic [1:0] WAVE_SINE  = 2'd1;
   localparam logic [1:0] WAVE_TABLE = 2'd2;

   // input transaction kinds
   localparam logic ITEM_WRITE = 1'b0;
   localparam logic ITEM_TICK  = 1'b1;

   // reset values of the configuration registers
   localparam logic [1:0]  WAVE_MODE_RST    = WAVE_SINE;
   localparam logic [31:0] PHASE_STEP_RST   = 32'd44739243;
   localparam logic [13:0] TABLE_LENGTH_RST = 14'd8192;

   // sample levels
   localparam logic signed [15:0] RECT_HIGH = 16'sd30000;
   localparam logic signed [15:0] RECT_LOW  = 16'sd0;
   localparam logic signed [15:0] TRIG_HIGH = 16'sd32500;
   localparam logic signed [15:0] TRIG_LOW  = -16'sd32500;

   // trigger burst: high until TRIG_SPLIT ticks, low until TRIG_END ticks
   localparam logic [6:0] TRIG_SPLIT = 7'd90;
   localparam logic [6:0] TRIG_END   = 7'd100;

   typedef enum logic [1:0] {
      TRIG_POS  = 2'b01,
      TRIG_NEG  = 2'b10,
      TRIG_NONE = 2'b00
   } trig_type;

endpackage

@@ rtl/xy_wavetable_oscillator_top.sv @@
// ----------------------------------------------------------------------------
// xy_wavetable_oscillator_top
// Two-channel DDS for an XY drive: rectangle, sine ROM, or mirrored point
// table addressed by a 32-bit phase accumulator.
// ----------------------------------------------------------------------------
// Path: accept reg, memory read reg, output reg, then rsp_valid. Throughput:
//   one transaction per cycle unless rsp_stall fills the pipeline, set by one
//   point store access per transaction and the registered sine ROM read.
// Reset: configuration returns to defaults, phase and trigger count clear.
//   The point store is not cleared; entries are undefined until written.
module xy_wavetable_oscillator_top
   import xywto_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096,
   parameter int SINE_DEPTH  = 1024
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_mode,
   input  logic [11:0]         req_point_index,
   input  logic signed [15:0]  req_point_x,
   input  logic signed [15:0]  req_point_y,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_left_sample,
   output logic signed [15:0]  rsp_right_sample
);

   localparam int TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SAW = $clog2(SINE_DEPTH);

   typedef logic signed [15:0] sine_rom_type [SINE_DEPTH];

   // rounded 32767-scale sine, ties away from zero
   function automatic sine_rom_type build_sine();
      sine_rom_type rom;
      real          v;
      for (int k = 0; k < SINE_DEPTH; k++) begin
         v = 32767.0 * $sin(2.0 * 3.14159265358979323846 * k / SINE_DEPTH);
         if (v >= 0.0) begin
            rom[k] = 16'($rtoi(v + 0.5));
         end else begin
            rom[k] = 16'(-$rtoi(-v + 0.5));
         end
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();

   // configuration
   logic [1:0]  wave_mode_ff;
   logic [31:0] phase_step_ff;
   logic [13:0] table_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_mode_ff    <= WAVE_MODE_RST;
         phase_step_ff   <= PHASE_STEP_RST;
         table_length_ff <= TABLE_LENGTH_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WAVE_MODE:    wave_mode_ff    <= csr_wdata[1:0];
            CSR_PHASE_STEP:   phase_step_ff   <= csr_wdata;
            CSR_TABLE_LENGTH: table_length_ff <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   // pipeline enables: each stage moves when the one after it is free
   logic a_valid_ff, b_valid_ff, rsp_valid_ff;
   logic c_en, b_en, a_en, req_take;

   assign c_en      = !rsp_valid_ff || !rsp_stall;
   assign b_en      = !b_valid_ff || c_en;
   assign a_en      = !a_valid_ff || b_en;
   assign req_stall = !a_en;
   assign req_take  = req_valid && a_en;

   // phase accumulator and trigger counter
   logic [31:0] phase_acc_ff, phase_acc_in;
   logic [6:0]  trigger_count_ff, trigger_count_in;
   logic        tick_take;

   assign tick_take = req_take && (req_mode == ITEM_TICK);

   always_comb begin
      phase_acc_in     = phase_acc_ff;
      trigger_count_in = trigger_count_ff;
      if (tick_take) begin
         phase_acc_in = phase_acc_ff + phase_step_ff;
         if (trigger_count_ff < TRIG_END) begin
            trigger_count_in = trigger_count_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff     <= '0;
         trigger_count_ff <= '0;
      end else begin
         phase_acc_ff     <= phase_acc_in;
         trigger_count_ff <= trigger_count_in;
      end
   end

   // stage A: addresses from the current phase
   logic [45:0]     tbl_prod;
   logic [32+SAW-1:0] sine_prod_l, sine_prod_r;
   logic [31:0]     phase_r;
   trig_type        trig_class;

   assign tbl_prod    = {14'b0, phase_acc_ff} * {32'b0, table_length_ff};
   assign phase_r     = phase_acc_ff + 32'h4000_0000;
   assign sine_prod_l = {{SAW{1'b0}}, phase_acc_ff} * (32+SAW)'(SINE_DEPTH);
   assign sine_prod_r = {{SAW{1'b0}}, phase_r} * (32+SAW)'(SINE_DEPTH);

   always_comb begin
      if (trigger_count_ff < TRIG_SPLIT) begin
         trig_class = TRIG_POS;
      end else if (trigger_count_ff < TRIG_END) begin
         trig_class = TRIG_NEG;
      end else begin
         trig_class = TRIG_NONE;
      end
   end

   logic               a_tick_ff;
   logic [1:0]         a_wave_ff;
   trig_type           a_trig_ff;
   logic               a_rect_ff;
   logic [13:0]        a_index_ff;
   logic [SAW-1:0]     a_sine_l_ff, a_sine_r_ff;
   logic [11:0]        a_point_index_ff;
   logic signed [15:0] a_point_x_ff, a_point_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_en) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_tick_ff        <= req_mode;
         a_wave_ff        <= wave_mode_ff;
         a_trig_ff        <= trig_class;
         a_rect_ff        <= phase_acc_ff[31];
         a_index_ff       <= tbl_prod[45:32];
         a_sine_l_ff      <= sine_prod_l[32+SAW-1:32];
         a_sine_r_ff      <= sine_prod_r[32+SAW-1:32];
         a_point_index_ff <= req_point_index;
         a_point_x_ff     <= req_point_x;
         a_point_y_ff     <= req_point_y;
      end
   end

   // mirrored table address
   logic [13:0]    half_len, mirror_idx, tbl_j;
   logic [TAW-1:0] tbl_addr, wr_addr;
   logic           mem_we;

   assign half_len   = table_length_ff >> 1;
   assign mirror_idx = table_length_ff - 14'd1 - a_index_ff;

   always_comb begin
      if (table_length_ff == 14'd0) begin
         tbl_j = '0;
      end else if (a_index_ff < half_len) begin
         tbl_j = a_index_ff;
      end else begin
         tbl_j = mirror_idx;
      end
      if (32'(tbl_j) >= 32'(TABLE_DEPTH)) begin
         tbl_addr = TAW'(TABLE_DEPTH - 1);
      end else begin
         tbl_addr = TAW'(tbl_j);
      end
   end

   // writes are issued from stage A so reads and writes keep item order
   assign wr_addr = TAW'(a_point_index_ff);
   assign mem_we  = a_valid_ff && b_en && (a_tick_ff == ITEM_WRITE)
                    && (32'(a_point_index_ff) < 32'(TABLE_DEPTH));

   // stage B: point store and sine ROM read registers
   logic signed [15:0] point_store_x [TABLE_DEPTH];
   logic signed [15:0] point_store_y [TABLE_DEPTH];
   logic signed [15:0] b_point_x_ff, b_point_y_ff;
   logic signed [15:0] b_sine_l_ff, b_sine_r_ff;
   logic [1:0]         b_wave_ff;
   trig_type           b_trig_ff;
   logic               b_rect_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         point_store_x[wr_addr] <= a_point_x_ff;
         point_store_y[wr_addr] <= a_point_y_ff;
      end
      if (b_en) begin
         b_point_x_ff <= point_store_x[tbl_addr];
         b_point_y_ff <= point_store_y[tbl_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (b_en) begin
         b_sine_l_ff <= SINE_ROM[a_sine_l_ff];
         b_sine_r_ff <= SINE_ROM[a_sine_r_ff];
         b_wave_ff   <= a_wave_ff;
         b_trig_ff   <= a_trig_ff;
         b_rect_ff   <= a_rect_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_en) begin
         b_valid_ff <= a_valid_ff && (a_tick_ff == ITEM_TICK);
      end
   end

   // stage C: output register
   logic signed [15:0] left_in, right_in;
   logic signed [15:0] rsp_left_ff, rsp_right_ff;

   always_comb begin
      case (b_wave_ff)
         WAVE_RECT: begin
            left_in  = b_rect_ff ? RECT_HIGH : RECT_LOW;
            right_in = b_rect_ff ? RECT_LOW  : RECT_HIGH;
         end
         WAVE_SINE: begin
            left_in  = b_sine_l_ff;
            right_in = b_sine_r_ff;
         end
         default: begin
            case (b_trig_ff)
               TRIG_POS: begin
                  left_in  = TRIG_HIGH;
                  right_in = TRIG_HIGH;
               end
               TRIG_NEG: begin
                  left_in  = TRIG_LOW;
                  right_in = TRIG_LOW;
               end
               default: begin
                  left_in  = b_point_x_ff;
                  right_in = b_point_y_ff;
               end
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (c_en) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_en && b_valid_ff) begin
         rsp_left_ff  <= left_in;
         rsp_right_ff <= right_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_sample  = rsp_left_ff;
   assign rsp_right_sample = rsp_right_ff;

`ifndef ASSERT_OFF
   a_trig_sat: assert property (@(posedge clock) disable iff (reset)
      trigger_count_ff <= TRIG_END)
      else $error("trigger count beyond saturation");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && b_valid_ff && rsp_valid_ff))
      else $error("input stalled with a free pipeline stage");

   a_phase_adv: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_mode == ITEM_TICK && !csr_we)
      |=> phase_acc_ff == $past(phase_acc_ff + phase_step_ff))
      else $error("phase did not advance by the step");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && b_en && a_tick_ff == ITEM_WRITE) |=> !b_valid_ff)
      else $error("write transaction produced a sample");
`endif

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the XY wavetable oscillator. A directed table
// covers reset values, rectangle levels, the start of the trigger burst and
// the table selector codes. Random phases then sweep mode, phase step and
// table length (zero, odd, beyond the store); both handshakes idle at
// random in the first eight phases. Every sample pair is compared against
// a cycle-free model of the oscillator kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
   import xywto_pkg::*;

   localparam int STORE_DEPTH    = 4096;
   localparam int SINE_LUT_DEPTH = 1024;
   localparam int DRAIN_GAP      = 8;
   localparam int HOLDOFF_CYCLES = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int NUM_PHASES     = 12;
   localparam real TWO_PI        = 6.283185307179586;
   localparam logic [1:0] WAVE_TABLE_ALT = 2'd3;

   typedef struct packed {
      logic               mode;
      logic [11:0]        index;
      logic signed [15:0] x;
      logic signed [15:0] y;
   } point_req_type;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
   } sample_pair_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      point_req_type   it;
      logic [1:0]      reg_idx;
      logic [31:0]     reg_val;
      bit              typed;
      sample_pair_type want;
   } dir_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_mode = 1'b0;
   logic [11:0]        req_point_index = '0;
   logic signed [15:0] req_point_x = '0;
   logic signed [15:0] req_point_y = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_left_sample;
   logic signed [15:0] rsp_right_sample;

   always #1ns clock = ~clock;

   xy_wavetable_oscillator_top uut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_point_index  (req_point_index),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_sample  (rsp_left_sample),
      .rsp_right_sample (rsp_right_sample)
   );

   // oscillator model state
   logic [1:0]         cfg_wave = WAVE_MODE_RST;
   logic [31:0]        cfg_step = PHASE_STEP_RST;
   logic [13:0]        cfg_len  = TABLE_LENGTH_RST;
   logic [31:0]        osc_phase = '0;
   int                 trig_ticks = 0;
   logic signed [15:0] store_x [STORE_DEPTH];
   logic signed [15:0] store_y [STORE_DEPTH];
   bit                 point_written [STORE_DEPTH];
   logic signed [15:0] sine_lut [SINE_LUT_DEPTH];

   sample_pair_type pending_samples [$];
   dir_row_type     dir_rows [$];
   int              mismatch_count = 0;
   int              send_idle_pct = 13;
   int              rcv_idle_pct = 58;
   bit              holdoff_req = 1'b0;
   int              holdoff_left = 0;
   int              stuck_cycles = 0;

   logic [1:0]  ph_wave  [NUM_PHASES];
   logic [31:0] ph_step  [NUM_PHASES];
   logic [13:0] ph_len   [NUM_PHASES];
   int          ph_items [NUM_PHASES];

   // append to the tail of the expected-result and stimulus queues
   function automatic void expect_sample(input sample_pair_type s);
      pending_samples.insert(pending_samples.size(), s);
   endfunction

   function automatic void add_row(input dir_row_type row);
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   // mirrored point address for a phase under the current table length
   function automatic logic [11:0] table_addr(input logic [31:0] ph);
      logic [63:0] prod;
      logic [31:0] len, i, j;
      len = 32'(cfg_len);
      prod = 64'(ph) * 64'(len);
      i = prod[63:32];
      if (len == 0)
         j = 0;
      else if (i < (len >> 1))
         j = i;
      else
         j = len - 1 - i;
      if (j >= STORE_DEPTH)
         j = STORE_DEPTH - 1;
      return j[11:0];
   endfunction

   task automatic calc_samples(input point_req_type it, output bit has_out,
                               output sample_pair_type res);
      logic [31:0] ph, ph_q;
      logic [11:0] j;
      ph = osc_phase;
      ph_q = ph + 32'h4000_0000;
      has_out = 1'b0;
      res = '0;
      if (it.mode == ITEM_WRITE) begin
         store_x[it.index] = it.x;
         store_y[it.index] = it.y;
         point_written[it.index] = 1'b1;
         return;
      end
      has_out = 1'b1;
      case (cfg_wave)
         WAVE_RECT: begin
            res.left  = ph[31] ? RECT_HIGH : RECT_LOW;
            res.right = ph[31] ? RECT_LOW : RECT_HIGH;
         end
         WAVE_SINE: begin
            // top 10 phase bits address the 1024-entry sine table
            res.left  = sine_lut[ph[31:22]];
            res.right = sine_lut[ph_q[31:22]];
         end
         default: begin
            if (trig_ticks < TRIG_SPLIT) begin
               res.left  = TRIG_HIGH;
               res.right = TRIG_HIGH;
            end else if (trig_ticks < TRIG_END) begin
               res.left  = TRIG_LOW;
               res.right = TRIG_LOW;
            end else begin
               j = table_addr(ph);
               res.left  = store_x[j];
               res.right = store_y[j];
            end
         end
      endcase
      osc_phase = ph + cfg_step;
      if (trig_ticks < TRIG_END)
         trig_ticks++;
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 100)
         $display("MISMATCH: %s (t=%0t)", msg, $time);
      mismatch_count++;
   endtask

   task automatic send_item(input point_req_type it, input bit use_typed,
                            input sample_pair_type typed);
      bit              has_out;
      sample_pair_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= it.mode;
      req_point_index <= it.index;
      req_point_x     <= it.x;
      req_point_y     <= it.y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      calc_samples(it, has_out, res);
      if (has_out)
         expect_sample(use_typed ? typed : res);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_WAVE_MODE:    cfg_wave = val[1:0];
         CSR_PHASE_STEP:   cfg_step = val;
         CSR_TABLE_LENGTH: cfg_len  = val[13:0];
         default: ;
      endcase
   endtask

   function automatic void dir_tick(input bit chk, input logic signed [15:0] l,
                                    input logic signed [15:0] r);
      dir_row_type row;
      row.kind = ROW_ITEM;
      row.it = '0;
      row.it.mode = ITEM_TICK;
      row.reg_idx = '0;
      row.reg_val = '0;
      row.typed = chk;
      row.want.left = l;
      row.want.right = r;
      add_row(row);
   endfunction

   function automatic void dir_write(input logic [11:0] idx, input logic signed [15:0] x,
                                     input logic signed [15:0] y);
      dir_row_type row;
      row.kind = ROW_ITEM;
      row.it.mode = ITEM_WRITE;
      row.it.index = idx;
      row.it.x = x;
      row.it.y = y;
      row.reg_idx = '0;
      row.reg_val = '0;
      row.typed = 1'b0;
      row.want = '0;
      add_row(row);
   endfunction

   function automatic void dir_csr(input logic [1:0] idx, input logic [31:0] val);
      dir_row_type row;
      row.kind = ROW_CSR;
      row.it = '0;
      row.reg_idx = idx;
      row.reg_val = val;
      row.typed = 1'b0;
      row.want = '0;
      add_row(row);
   endfunction

   function automatic void plan_phase(input int p, input logic [1:0] wave,
                                      input logic [31:0] step, input logic [13:0] len,
                                      input int n);
      ph_wave[p]  = wave;
      ph_step[p]  = step;
      ph_len[p]   = len;
      ph_items[p] = n;
   endfunction

   // receiver: random stall, or a long hold-off when requested
   always @(posedge clock) begin
      if (holdoff_req) begin
         holdoff_req = 1'b0;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      sample_pair_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction left=%0d right=%0d",
                                      rsp_left_sample, rsp_right_sample));
         end else begin
            want = pending_samples.pop_front();
            if (rsp_left_sample !== want.left)
               report_mismatch($sformatf("left_sample got %0d want %0d",
                                         rsp_left_sample, want.left));
            if (rsp_right_sample !== want.right)
               report_mismatch($sformatf("right_sample got %0d want %0d",
                                         rsp_right_sample, want.right));
         end
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d results outstanding", pending_samples.size());
         $display("status: fail");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      real           amp;
      int            k, p, n;
      point_req_type it, fill;
      logic [11:0]   addr;

      for (k = 0; k < SINE_LUT_DEPTH; k++) begin
         amp = 32767.0 * $sin(TWO_PI * k / SINE_LUT_DEPTH);
         sine_lut[k] = (amp >= 0.0) ? 16'($rtoi($floor(amp + 0.5)))
                                    : 16'(-$rtoi($floor(0.5 - amp)));
      end
      for (k = 0; k < STORE_DEPTH; k++)
         point_written[k] = 1'b0;

      // directed table; phase is 0 after reset, sine mode
      dir_tick(1'b1, 16'sd0, 16'sd32767);
      dir_csr(CSR_WAVE_MODE, 32'(WAVE_RECT));
      dir_csr(CSR_PHASE_STEP, 32'h8000_0000);
      dir_tick(1'b1, RECT_LOW, RECT_HIGH);
      dir_tick(1'b1, RECT_HIGH, RECT_LOW);
      dir_csr(CSR_PHASE_STEP, 32'h0);
      dir_tick(1'b1, RECT_LOW, RECT_HIGH);
      dir_tick(1'b1, RECT_LOW, RECT_HIGH);
      dir_csr(CSR_WAVE_MODE, 32'(WAVE_SINE));
      dir_csr(CSR_PHASE_STEP, 32'hFFFF_FFFF);
      dir_tick(1'b0, '0, '0);
      dir_tick(1'b0, '0, '0);
      dir_csr(CSR_WAVE_MODE, 32'(WAVE_TABLE));
      dir_write(12'd0, 16'sh8000, 16'sh7fff);
      dir_write(12'd4095, 16'sh7fff, 16'sh8000);
      dir_write(12'haaa, 16'sh5555, 16'shaaaa);
      dir_write(12'h555, 16'shaaaa, 16'sh5555);
      // trigger burst still running: ticks since reset well below the split
      dir_tick(1'b1, TRIG_HIGH, TRIG_HIGH);
      dir_csr(CSR_WAVE_MODE, 32'(WAVE_TABLE_ALT));
      dir_tick(1'b1, TRIG_HIGH, TRIG_HIGH);
      dir_csr(CSR_TABLE_LENGTH, 32'd2);
      dir_tick(1'b1, TRIG_HIGH, TRIG_HIGH);

      // random phases; the first one finishes the trigger burst
      plan_phase(0,  WAVE_TABLE,     $urandom, 14'd16, 200);
      plan_phase(1,  WAVE_TABLE,     $urandom, 14'd8192, 130);
      plan_phase(2,  WAVE_RECT,      $urandom, 14'($urandom_range(8192, 2)), 130);
      plan_phase(3,  WAVE_SINE,      $urandom, 14'($urandom_range(8192, 2)), 130);
      plan_phase(4,  WAVE_TABLE,     $urandom, 14'd0, 110);
      plan_phase(5,  WAVE_TABLE_ALT, $urandom, 14'h3fff, 130);
      plan_phase(6,  WAVE_TABLE,     $urandom, 14'd2, 110);
      plan_phase(7,  WAVE_SINE,      32'hFFFF_FFFF, 14'd100, 110);
      plan_phase(8,  WAVE_TABLE,     $urandom, 14'd13, 110);
      plan_phase(9,  WAVE_TABLE,     $urandom, 14'($urandom_range(64, 2)), 130);
      plan_phase(10, WAVE_RECT,      32'h8000_0000, 14'($urandom_range(8192, 2)), 110);
      plan_phase(11, WAVE_TABLE,     $urandom, 14'(4096 + $urandom_range(4096)), 150);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_CSR) begin
            wait_drain();
            write_csr(dir_rows[r].reg_idx, dir_rows[r].reg_val);
         end else begin
            send_item(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].want);
         end
      end

      for (p = 0; p < NUM_PHASES; p++) begin
         wait_drain();
         if (p < 4) begin
            send_idle_pct = 13;
            rcv_idle_pct = 58;
         end else if (p < 8) begin
            send_idle_pct = 58;
            rcv_idle_pct = 13;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         write_csr(CSR_WAVE_MODE, 32'(ph_wave[p]));
         write_csr(CSR_PHASE_STEP, ph_step[p]);
         write_csr(CSR_TABLE_LENGTH, 32'(ph_len[p]));
         for (n = 0; n < ph_items[p]; n++) begin
            if (p == 1 && n == 30)
               holdoff_req = 1'b1;
            if (p == 2 && n == ph_items[p] / 2)
               wait_drain();
            it.index = 12'($urandom_range(4095));
            it.x = 16'($urandom);
            it.y = 16'($urandom);
            if ($urandom_range(99) < 30) begin
               it.mode = ITEM_WRITE;
            end else begin
               it.mode = ITEM_TICK;
               // never let the table read a point that was not loaded
               if (cfg_wave >= WAVE_TABLE && trig_ticks >= TRIG_END) begin
                  addr = table_addr(osc_phase);
                  if (!point_written[addr]) begin
                     fill.mode = ITEM_WRITE;
                     fill.index = addr;
                     fill.x = 16'($urandom);
                     fill.y = 16'($urandom);
                     send_item(fill, 1'b0, '0);
                     // the fill counts toward the phase's item budget
                     n++;
                  end
               end
            end
            send_item(it, 1'b0, '0);
         end
      end

      wait_drain();
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/xywto_pkg.sv
rtl/xy_wavetable_oscillator_top.sv
bench/tb_top.sv
